// ===== src/bfpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpv_pkg
// Shared types and codes for the MSB-first bit packer with varint prefix.
// ----------------------------------------------------------------------------
package bfpv_pkg;

  // Field modes
  localparam logic [2:0] MODE_FIXED_U = 3'd0;
  localparam logic [2:0] MODE_FIXED_S = 3'd1;
  localparam logic [2:0] MODE_DYN_U   = 3'd2;
  localparam logic [2:0] MODE_DYN_S   = 3'd3;
  localparam logic [2:0] MODE_ALIGN   = 3'd4;
  localparam logic [2:0] MODE_END     = 3'd5;

  // Width of the value field and the per-item result cap
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned MaxResults = 8;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [5:0]  width;
  } bfpv_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        error;
    logic [31:0] bit_count;
  } bfpv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GROW,
    ST_BUILD,
    ST_ALIGN,
    ST_EMIT,
    ST_ERROR
  } bfpv_state_e;

  typedef struct packed {
    logic load;
    logic flush;
    logic grow;
    logic build;
    logic align;
    logic emit;
    logic finish;
    logic send_err;
  } bfpv_cmd_t;

  typedef struct packed {
    logic field_mode;
    logic dyn_mode;
    logic width_bad;
    logic grow_more;
    logic fit_err;
    logic rem_ge8;
    logic capped;
    logic any_byte;
    logic slot_free;
  } bfpv_status_t;

endpackage

// ===== src/bfpv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpv_ctrl
// Bit packer sequencer: decode, prefix growth, build, align, emit, error.
// ----------------------------------------------------------------------------
module bfpv_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bfpv_pkg::bfpv_status_t status_i,
  output bfpv_pkg::bfpv_cmd_t    cmd_o
);

  bfpv_pkg::bfpv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfpv_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bfpv_pkg::ST_DECODE;
      end
      bfpv_pkg::ST_DECODE: begin
        if (!status_i.field_mode) begin
          state_d = bfpv_pkg::ST_EMIT;
        end else if (status_i.width_bad) begin
          state_d = bfpv_pkg::ST_ERROR;
        end else if (status_i.dyn_mode) begin
          state_d = bfpv_pkg::ST_GROW;
        end else begin
          state_d = bfpv_pkg::ST_BUILD;
        end
      end
      bfpv_pkg::ST_GROW: begin
        if (!status_i.grow_more) state_d = bfpv_pkg::ST_BUILD;
      end
      bfpv_pkg::ST_BUILD: begin
        state_d = status_i.fit_err ? bfpv_pkg::ST_ERROR : bfpv_pkg::ST_ALIGN;
      end
      bfpv_pkg::ST_ALIGN: begin
        state_d = bfpv_pkg::ST_EMIT;
      end
      bfpv_pkg::ST_EMIT: begin
        if (!status_i.rem_ge8 && (status_i.any_byte || status_i.slot_free)) begin
          state_d = bfpv_pkg::ST_IDLE;
        end
      end
      bfpv_pkg::ST_ERROR: begin
        if (status_i.slot_free) state_d = bfpv_pkg::ST_IDLE;
      end
      default: state_d = bfpv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bfpv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      bfpv_pkg::ST_DECODE: cmd_o.flush = !status_i.field_mode;
      bfpv_pkg::ST_GROW:   cmd_o.grow  = status_i.grow_more;
      bfpv_pkg::ST_BUILD:  cmd_o.build = !status_i.fit_err;
      bfpv_pkg::ST_ALIGN:  cmd_o.align = 1'b1;
      bfpv_pkg::ST_EMIT: begin
        // dropped bytes past the cap need no output slot
        if (status_i.rem_ge8) begin
          cmd_o.emit = status_i.capped || status_i.slot_free;
        end else begin
          cmd_o.finish = status_i.any_byte || status_i.slot_free;
        end
      end
      bfpv_pkg::ST_ERROR:  cmd_o.send_err = status_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/bfpv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpv_datapath
// Field registers, prefix growth, bit word assembly, byte shifter and
// the output register of the bit packer.
// ----------------------------------------------------------------------------
module bfpv_datapath #(
  parameter int unsigned MaxFieldBits = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfpv_pkg::bfpv_in_t     in_data_i,
  input  bfpv_pkg::bfpv_cmd_t    cmd_i,
  output bfpv_pkg::bfpv_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bfpv_pkg::bfpv_out_t    out_data_o
);

  // pending bits + unary prefix + stop bit + payload
  localparam int unsigned WordBits = 2 * MaxFieldBits + 8;
  localparam int unsigned NW = $clog2(WordBits + 1);
  localparam int unsigned SW = $clog2(MaxFieldBits + 64);
  localparam int unsigned OW = $clog2(MaxFieldBits);
  localparam int unsigned IW = $clog2(bfpv_pkg::MaxResults);
  localparam logic [SW-1:0] MaxS = SW'(MaxFieldBits);

  logic [2:0]          mode_q;
  logic [31:0]         value_q;
  logic [5:0]          width_q;
  logic [SW-1:0]       shift_q, shift_d;
  logic [OW-1:0]       ones_q, ones_d;
  logic [WordBits-1:0] word_q, word_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                capped_q, capped_d;
  logic [6:0]          pend_bits_q, pend_bits_d;
  logic [2:0]          pend_cnt_q, pend_cnt_d;
  logic [31:0]         total_q, total_d;
  logic [31:0]         report_q, report_d;
  logic                out_valid_q, out_valid_d;
  bfpv_pkg::bfpv_out_t out_q, out_d;

  logic                is_signed;
  logic                zero_bit;
  logic [SW-1:0]       len;
  logic [NW-1:0]       nbits;
  logic [NW-1:0]       len_z;
  logic [WordBits-1:0] vext;
  logic [WordBits-1:0] field_word;
  logic [WordBits-1:0] pend_word;
  logic [32:0]         sum_field;
  logic [32:0]         sum_pad;
  logic [3:0]          pad;
  logic [7:0]          pend_lj;
  logic [7:0]          top_byte;
  logic [7:0]          residue;
  logic                slot_free;
  logic                emit_out;
  logic                empty_out;

  // true when the held value fits in n bits under the current mode
  function automatic logic fits_n(input logic [31:0] v, input logic sgn,
                                  input logic [SW-1:0] n);
    logic [31:0]   u;
    logic [SW-1:0] k;
    u = sgn ? (v ^ {32{v[31]}}) : v;
    k = sgn ? (n - SW'(1)) : n;
    return (k >= SW'(bfpv_pkg::ValueBits)) || ((u >> k[4:0]) == 32'd0);
  endfunction

  function automatic logic [WordBits-1:0] thermo(input logic [NW-1:0] n);
    logic [WordBits-1:0] m;
    for (int i = 0; i < WordBits; i++) begin
      m[i] = NW'(i) < n;
    end
    return m;
  endfunction

  assign is_signed = (mode_q == bfpv_pkg::MODE_FIXED_S) || (mode_q == bfpv_pkg::MODE_DYN_S);
  assign zero_bit  = (mode_q == bfpv_pkg::MODE_DYN_U || mode_q == bfpv_pkg::MODE_DYN_S)
                     && (shift_q < MaxS);
  assign len       = (zero_bit || !(mode_q == bfpv_pkg::MODE_DYN_U ||
                                    mode_q == bfpv_pkg::MODE_DYN_S) || shift_q < MaxS)
                     ? shift_q : MaxS;
  assign len_z     = NW'(len) + NW'(zero_bit);
  assign nbits     = len_z + NW'(ones_q);

  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      vext[i] = (i < 32) ? value_q[i % 32] : (is_signed & value_q[31]);
    end
  end

  // prefix ones sit above the stop bit, payload at the bottom
  assign field_word = (thermo(nbits) & ~thermo(len_z)) | (vext & thermo(NW'(len)));
  assign pend_word  = WordBits'(pend_bits_q) << nbits;
  assign sum_field  = {1'b0, total_q} + 33'(nbits);
  assign pad        = (pend_cnt_q != 3'd0) ? (4'd8 - {1'b0, pend_cnt_q}) : 4'd0;
  assign sum_pad    = {1'b0, total_q} + 33'(pad);
  assign pend_lj    = {1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q});
  assign top_byte   = word_q[WordBits-1 -: 8];
  assign residue    = top_byte >> (4'd8 - {1'b0, rem_q[2:0]});

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign emit_out   = cmd_i.emit && !capped_q;
  assign empty_out  = cmd_i.finish && (idx_q == '0) && !capped_q;

  always_comb begin
    shift_d     = shift_q;
    ones_d      = ones_q;
    word_d      = word_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    capped_d    = capped_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    total_d     = total_q;
    report_d    = report_q;

    if (cmd_i.load) begin
      shift_d  = SW'(in_data_i.width);
      ones_d   = '0;
      idx_d    = '0;
      capped_d = 1'b0;
    end
    if (cmd_i.grow) begin
      ones_d  = ones_q + OW'(1);
      shift_d = shift_q + SW'(width_q);
    end
    if (cmd_i.build) begin
      word_d   = field_word | pend_word;
      rem_d    = nbits + NW'(pend_cnt_q);
      total_d  = sum_field[32] ? '1 : sum_field[31:0];
      report_d = total_d;
    end
    if (cmd_i.align) begin
      word_d = word_q << (NW'(WordBits) - rem_q);
    end
    if (cmd_i.flush) begin
      word_d = {pend_lj, {(WordBits - 8){1'b0}}};
      priority if (mode_q == bfpv_pkg::MODE_ALIGN) begin
        rem_d    = (pend_cnt_q != 3'd0) ? NW'(8) : '0;
        total_d  = sum_pad[32] ? '1 : sum_pad[31:0];
        report_d = total_d;
      end else if (mode_q == bfpv_pkg::MODE_END) begin
        rem_d    = (pend_cnt_q != 3'd0) ? NW'(8) : '0;
        report_d = total_q;
        total_d  = '0;
      end else begin
        // unused mode: hand the pending bits back untouched
        rem_d    = NW'(pend_cnt_q);
        report_d = total_q;
      end
    end
    if (cmd_i.emit) begin
      word_d = word_q << 8;
      rem_d  = rem_q - NW'(8);
      if (!capped_q) begin
        idx_d    = idx_q + IW'(1);
        capped_d = (idx_q == IW'(bfpv_pkg::MaxResults - 1));
      end
    end
    if (cmd_i.finish) begin
      pend_bits_d = residue[6:0];
      pend_cnt_d  = rem_q[2:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (emit_out) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = top_byte;
      out_d.byte_valid = 1'b1;
      out_d.last       = (rem_q < NW'(16)) || (idx_q == IW'(bfpv_pkg::MaxResults - 1));
      out_d.error      = 1'b0;
      out_d.bit_count  = report_q;
    end else if (empty_out || cmd_i.send_err) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = 8'd0;
      out_d.byte_valid = 1'b0;
      out_d.last       = 1'b1;
      out_d.error      = cmd_i.send_err;
      out_d.bit_count  = cmd_i.send_err ? total_q : report_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_data_i.mode;
      value_q <= in_data_i.value;
      width_q <= in_data_i.width;
    end
    shift_q  <= shift_d;
    ones_q   <= ones_d;
    word_q   <= word_d;
    rem_q    <= rem_d;
    idx_q    <= idx_d;
    capped_q <= capped_d;
    report_q <= report_d;
    out_q    <= out_d;
  end

  always_comb begin
    status_o.field_mode = (mode_q <= bfpv_pkg::MODE_DYN_S);
    status_o.dyn_mode   = (mode_q == bfpv_pkg::MODE_DYN_U) || (mode_q == bfpv_pkg::MODE_DYN_S);
    status_o.width_bad  = (width_q == 6'd0) || (SW'(width_q) > MaxS);
    status_o.grow_more  = (shift_q < MaxS) && !fits_n(value_q, is_signed, shift_q);
    status_o.fit_err    = !fits_n(value_q, is_signed, len);
    status_o.rem_ge8    = rem_q >= NW'(8);
    status_o.capped     = capped_q;
    status_o.any_byte   = (idx_q != '0) || capped_q;
    status_o.slot_free  = slot_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/bit_field_packer_varint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_packer_varint
// MSB-first bit packer with fixed, signed and unary-prefix varint fields.
// ----------------------------------------------------------------------------
// Takes one item at a time. A fixed field passes through decode, build, align
// and emit, with one emit step per output byte; a dynamic field adds one grow
// step per extra width group plus the final check, since the prefix length is
// found by a single add-and-check step per cycle. Align, end and the unused
// modes go from decode straight to emit; an error result is sent from the
// error state, entered from decode or build. An output stall holds the
// sequence while a result waits. The byte shifter hands out at most one byte
// per cycle; the last result of an item sits in the output register while the
// next item is accepted.
module bit_field_packer_varint #(
  parameter int unsigned MaxFieldBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfpv_pkg::bfpv_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfpv_pkg::bfpv_out_t out_data_o
);

  bfpv_pkg::bfpv_cmd_t    cmd;
  bfpv_pkg::bfpv_status_t status;

  bfpv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bfpv_datapath #(
    .MaxFieldBits (MaxFieldBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/bfpv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpv_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module bfpv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bfpv_pkg::bfpv_out_t out_data_o
);

  // a rejected field yields a single empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.last && !out_data_o.byte_valid)
    else $error("error transaction must be a last, empty result");

  // an empty result carries a zero byte and closes the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'd0 && out_data_o.last)
    else $error("empty result must be last with a zero byte");

  // hold off the next transaction while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

endmodule

bind bit_field_packer_varint bfpv_checker u_bfpv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
